@@ hdl/matrix_keypad_debouncer_macros.svh @@
// ----------------------------------------------------------------------------
// Keypad debouncer assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_DEBOUNCER_MACROS_SVH
`define MATRIX_KEYPAD_DEBOUNCER_MACROS_SVH

// Same-cycle implication.
`define KPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/kpd_pkg.sv @@
// ----------------------------------------------------------------------------
// kpd_pkg
// Sizes, phase encoding and shared types of the keypad debouncer.
// ----------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

    localparam int KEY_ROWS  = 4;
    localparam int KEY_COLS  = 4;
    localparam int NKEYS     = KEY_ROWS * KEY_COLS;
    localparam int LEVEL_W   = 4;
    localparam int SCAN_COLS = (KEY_COLS < LEVEL_W) ? KEY_COLS : LEVEL_W;
    localparam int ROW_IN_W  = 2;
    localparam int ROW_W     = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;
    localparam int ROW_IW    = (ROW_W > ROW_IN_W) ? ROW_W : ROW_IN_W;
    localparam int CODE_W    = 4;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [TIME_W-1:0] PRESS_HOLD_RST   = TIME_W'(10000);
    localparam logic [TIME_W-1:0] RELEASE_HOLD_RST = TIME_W'(100000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_HOLD   = 1'b0,
        CFG_RELEASE_HOLD = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PEND_ON  = 2'd1,
        PH_DOWN     = 2'd2,
        PH_PEND_OFF = 2'd3
    } key_phase_t;

    typedef struct packed {
        key_phase_t        phase;
        logic [TIME_W-1:0] press_stamp;
        logic [TIME_W-1:0] release_stamp;
    } key_state_t;

    typedef struct packed {
        logic [TIME_W-1:0] press_hold;
        logic [TIME_W-1:0] release_hold;
    } hold_cfg_t;

    typedef struct packed {
        logic              key_valid;
        logic [CODE_W-1:0] key_code;
    } key_result_t;

    // row * KEY_COLS + col, low bits only
    function automatic logic [CODE_W-1:0] key_code_of(input logic [ROW_W-1:0] row,
                                                      input int col);
        int k;
        k = int'(row) * KEY_COLS + col;
        return CODE_W'(k);
    endfunction

endpackage

`default_nettype wire

@@ hdl/kpd_key_update.sv @@
// ----------------------------------------------------------------------------
// kpd_key_update
// Next state of one key's debounce machine for one column sample.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_key_update (
    input  var kpd_pkg::key_state_t         state_i,
    input  wire logic                       high_i,
    input  wire logic [kpd_pkg::TIME_W-1:0] now_us_i,
    input  var kpd_pkg::hold_cfg_t          hold_i,
    output kpd_pkg::key_state_t             state_next_o,
    output logic                            confirm_o
);

    logic [kpd_pkg::TIME_W-1:0] press_elapsed;
    logic [kpd_pkg::TIME_W-1:0] release_elapsed;
    logic                       press_done;
    logic                       release_done;
    kpd_pkg::key_phase_t        phase_next;

    // wraps modulo 2^32
    assign press_elapsed   = now_us_i - state_i.press_stamp;
    assign release_elapsed = now_us_i - state_i.release_stamp;
    assign press_done      = (press_elapsed >= hold_i.press_hold);
    assign release_done    = (release_elapsed >= hold_i.release_hold);

    always_comb begin
        phase_next = state_i.phase;
        if (high_i) begin
            unique case (state_i.phase)
                kpd_pkg::PH_DOWN: begin
                    phase_next = kpd_pkg::PH_PEND_OFF;
                end
                kpd_pkg::PH_PEND_OFF: begin
                    if (release_done) begin
                        phase_next = kpd_pkg::PH_IDLE;
                    end
                end
                default: begin
                    phase_next = kpd_pkg::PH_IDLE;
                end
            endcase
        end else begin
            unique case (state_i.phase)
                kpd_pkg::PH_IDLE: begin
                    phase_next = kpd_pkg::PH_PEND_ON;
                end
                kpd_pkg::PH_PEND_ON: begin
                    if (press_done) begin
                        phase_next = kpd_pkg::PH_DOWN;
                    end
                end
                default: begin
                    phase_next = kpd_pkg::PH_DOWN;
                end
            endcase
        end
    end

    always_comb begin
        state_next_o.phase         = phase_next;
        state_next_o.press_stamp   = state_i.press_stamp;
        state_next_o.release_stamp = state_i.release_stamp;
        if (!high_i && state_i.phase == kpd_pkg::PH_IDLE) begin
            state_next_o.press_stamp = now_us_i;
        end
        if (high_i && state_i.phase == kpd_pkg::PH_DOWN) begin
            state_next_o.release_stamp = now_us_i;
        end
        confirm_o = !high_i && (state_i.phase == kpd_pkg::PH_PEND_ON) && press_done;
    end

endmodule

`default_nettype wire

@@ hdl/kpd_row_engine.sv @@
// ----------------------------------------------------------------------------
// kpd_row_engine
// Per-key state store; updates the sampled row's keys and picks the report.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_row_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          upd_en,
    input  wire logic [kpd_pkg::ROW_IN_W-1:0]  row_index,
    input  wire logic [kpd_pkg::LEVEL_W-1:0]   column_levels,
    input  wire logic [kpd_pkg::TIME_W-1:0]    now_us,
    input  var kpd_pkg::hold_cfg_t             hold,
    output kpd_pkg::key_result_t               result
);

    kpd_pkg::key_phase_t        phase_reg         [kpd_pkg::KEY_ROWS][kpd_pkg::KEY_COLS];
    logic [kpd_pkg::TIME_W-1:0] press_stamp_reg   [kpd_pkg::KEY_ROWS][kpd_pkg::KEY_COLS];
    logic [kpd_pkg::TIME_W-1:0] release_stamp_reg [kpd_pkg::KEY_ROWS][kpd_pkg::KEY_COLS];

    logic [kpd_pkg::ROW_IW-1:0]  row_wide;
    logic [kpd_pkg::ROW_W-1:0]   row_sel;
    logic                        row_ok;
    kpd_pkg::key_state_t         cur_state  [kpd_pkg::SCAN_COLS];
    kpd_pkg::key_state_t         next_state [kpd_pkg::SCAN_COLS];
    logic [kpd_pkg::SCAN_COLS-1:0] confirm;
    logic [kpd_pkg::SCAN_COLS-1:0] wr_en;

    assign row_wide = kpd_pkg::ROW_IW'(row_index);
    assign row_sel  = row_wide[kpd_pkg::ROW_W-1:0];
    assign row_ok   = ({1'b0, row_wide} < (kpd_pkg::ROW_IW + 1)'(kpd_pkg::KEY_ROWS));

    for (genvar j = 0; j < kpd_pkg::SCAN_COLS; j++) begin : g_col
        always_comb begin
            cur_state[j].phase         = phase_reg[row_sel][j];
            cur_state[j].press_stamp   = press_stamp_reg[row_sel][j];
            cur_state[j].release_stamp = release_stamp_reg[row_sel][j];
        end

        kpd_key_update u_key (
            .state_i      (cur_state[j]),
            .high_i       (column_levels[j]),
            .now_us_i     (now_us),
            .hold_i       (hold),
            .state_next_o (next_state[j]),
            .confirm_o    (confirm[j])
        );
    end

    // columns after the first confirmed key keep their state
    always_comb begin
        logic taken;
        taken  = 1'b0;
        result = '0;
        for (int j = 0; j < kpd_pkg::SCAN_COLS; j++) begin
            wr_en[j] = upd_en && row_ok && !taken;
            if (!taken && confirm[j]) begin
                result.key_valid = 1'b1;
                result.key_code  = kpd_pkg::key_code_of(row_sel, j);
                taken            = 1'b1;
            end
        end
        if (!row_ok) begin
            result = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < kpd_pkg::KEY_ROWS; r++) begin
                for (int c = 0; c < kpd_pkg::KEY_COLS; c++) begin
                    phase_reg[r][c] <= kpd_pkg::PH_IDLE;
                end
            end
        end else begin
            for (int j = 0; j < kpd_pkg::SCAN_COLS; j++) begin
                if (wr_en[j]) begin
                    phase_reg[row_sel][j] <= next_state[j].phase;
                end
            end
        end
    end

    // stamps are only read in phases that wrote them first
    always_ff @(posedge aclk) begin
        for (int j = 0; j < kpd_pkg::SCAN_COLS; j++) begin
            if (wr_en[j]) begin
                press_stamp_reg[row_sel][j]   <= next_state[j].press_stamp;
                release_stamp_reg[row_sel][j] <= next_state[j].release_stamp;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/matrix_keypad_debouncer.sv @@
// ----------------------------------------------------------------------------
// matrix_keypad_debouncer
// Debounces a scanned 4x4 key matrix, one row sample per request.
// ----------------------------------------------------------------------------
//  channel  | ports                                        | direction
//  ---------+----------------------------------------------+----------
//  s_       | s_row_index, s_column_levels, s_now_us       | in
//  m_       | m_key_valid, m_key_code                      | out
//  cfg_     | cfg_index, cfg_data                          | in
//
//  One request per cycle sustained while results are taken; a request passes
//  the input register, then the key update into the result register.
//  The per-key state read and write-back of the sampled row sets the path.
//  Synchronous active-low reset puts every key idle and loads default holds.
//  A stalled result holds the result register; one more request waits in
//  the input register, after which s_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "matrix_keypad_debouncer_macros.svh"

module matrix_keypad_debouncer (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [kpd_pkg::ROW_IN_W-1:0]   s_row_index,
    input  wire logic [kpd_pkg::LEVEL_W-1:0]    s_column_levels,
    input  wire logic [kpd_pkg::TIME_W-1:0]     s_now_us,

    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_key_valid,
    output logic [kpd_pkg::CODE_W-1:0]          m_key_code,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [kpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kpd_pkg::TIME_W-1:0]     cfg_data
);

    logic                          in_valid_reg;
    logic [kpd_pkg::ROW_IN_W-1:0]  row_reg;
    logic [kpd_pkg::LEVEL_W-1:0]   levels_reg;
    logic [kpd_pkg::TIME_W-1:0]    now_reg;

    logic                          out_valid_reg;
    kpd_pkg::key_result_t          result_reg;
    kpd_pkg::key_result_t          result_next;

    logic [kpd_pkg::TIME_W-1:0]    press_hold_reg;
    logic [kpd_pkg::TIME_W-1:0]    release_hold_reg;
    kpd_pkg::hold_cfg_t            hold;

    logic out_free;
    logic advance;
    logic s_fire;
    logic cfg_fire;

    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign hold.press_hold   = press_hold_reg;
    assign hold.release_hold = release_hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_hold_reg   <= kpd_pkg::PRESS_HOLD_RST;
            release_hold_reg <= kpd_pkg::RELEASE_HOLD_RST;
        end else if (cfg_fire) begin
            unique case (kpd_pkg::cfg_index_t'(cfg_index))
                kpd_pkg::CFG_PRESS_HOLD:   press_hold_reg   <= cfg_data;
                kpd_pkg::CFG_RELEASE_HOLD: release_hold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            row_reg    <= s_row_index;
            levels_reg <= s_column_levels;
            now_reg    <= s_now_us;
        end
    end

    kpd_row_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .upd_en        (advance),
        .row_index     (row_reg),
        .column_levels (levels_reg),
        .now_us        (now_reg),
        .hold          (hold),
        .result        (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_key_valid = result_reg.key_valid;
    assign m_key_code  = result_reg.key_code;

    `KPD_ASSERT_NOW(a_code_zero_when_no_key, m_valid && !m_key_valid, m_key_code == '0, "key code set without a confirmed key")

    `KPD_ASSERT_NEXT(a_stage_moves_to_output, in_valid_reg && (!m_valid || m_ready), m_valid, "buffered request did not reach the output")

    `KPD_ASSERT_NEXT(a_press_hold_written, cfg_valid && cfg_ready && cfg_index == kpd_pkg::CFG_PRESS_HOLD, press_hold_reg == $past(cfg_data), "press hold write lost")

endmodule

`default_nettype wire

@@ tb/matrix_keypad_debouncer_tb.sv @@
// ----------------------------------------------------------------------------
// matrix_keypad_debouncer_tb
// Self-checking bench for the 4x4 keypad debouncer. A behavioral scan model
// predicts the key report of every row sample. The bench covers hand-made
// press, release and wrap cases, then random scans under several hold
// settings with random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_keypad_debouncer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_STALL  = 60;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    logic [kpd_pkg::ROW_IN_W-1:0]   s_row_index;
    logic [kpd_pkg::LEVEL_W-1:0]    s_column_levels;
    logic [kpd_pkg::TIME_W-1:0]     s_now_us;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_key_valid;
    logic [kpd_pkg::CODE_W-1:0]     m_key_code;
    logic                           cfg_valid;
    logic                           cfg_ready;
    kpd_pkg::cfg_index_t            cfg_index;
    logic [kpd_pkg::TIME_W-1:0]     cfg_data;

    // scan model state
    kpd_pkg::key_phase_t            key_phase_m [kpd_pkg::NKEYS];
    logic [kpd_pkg::TIME_W-1:0]     press_at    [kpd_pkg::NKEYS];
    logic [kpd_pkg::TIME_W-1:0]     release_at  [kpd_pkg::NKEYS];
    logic [kpd_pkg::TIME_W-1:0]     press_hold_m;
    logic [kpd_pkg::TIME_W-1:0]     release_hold_m;
    kpd_pkg::key_result_t           pending_reports[$];

    // stimulus state
    logic [kpd_pkg::LEVEL_W-1:0]    held_keys [kpd_pkg::KEY_ROWS];
    logic [kpd_pkg::TIME_W-1:0]     clock_us;
    bit                             idle_enable;
    bit                             long_stall_req;
    int                             fail_count;
    int                             samples_sent;
    int                             presses_seen;
    int                             hold_settings;
    int                             quiet_cycles;

    matrix_keypad_debouncer i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_row_index     (s_row_index),
        .s_column_levels (s_column_levels),
        .s_now_us        (s_now_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_key_valid     (m_key_valid),
        .m_key_code      (m_key_code),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Advances the keys of one row; columns in order, stop after a confirm.
    function automatic kpd_pkg::key_result_t debounce_row(
            input logic [kpd_pkg::ROW_IN_W-1:0] row,
            input logic [kpd_pkg::LEVEL_W-1:0]  levels,
            input logic [kpd_pkg::TIME_W-1:0]   now);
        kpd_pkg::key_result_t res;
        int                   k;
        res = '0;
        if (int'(row) >= kpd_pkg::KEY_ROWS)
            return res;
        for (int j = 0; j < kpd_pkg::SCAN_COLS; j++) begin
            k = int'(row) * kpd_pkg::KEY_COLS + j;
            if (k >= kpd_pkg::NKEYS)
                break;
            if (levels[j]) begin
                case (key_phase_m[k])
                    kpd_pkg::PH_DOWN: begin
                        release_at[k]  = now;
                        key_phase_m[k] = kpd_pkg::PH_PEND_OFF;
                    end
                    kpd_pkg::PH_PEND_OFF: begin
                        if (kpd_pkg::TIME_W'(now - release_at[k]) >= release_hold_m)
                            key_phase_m[k] = kpd_pkg::PH_IDLE;
                    end
                    default: key_phase_m[k] = kpd_pkg::PH_IDLE;
                endcase
            end else begin
                case (key_phase_m[k])
                    kpd_pkg::PH_IDLE: begin
                        press_at[k]    = now;
                        key_phase_m[k] = kpd_pkg::PH_PEND_ON;
                    end
                    kpd_pkg::PH_PEND_ON: begin
                        if (kpd_pkg::TIME_W'(now - press_at[k]) >= press_hold_m) begin
                            key_phase_m[k] = kpd_pkg::PH_DOWN;
                            res.key_valid  = 1'b1;
                            res.key_code   = k[kpd_pkg::CODE_W-1:0];
                            return res;
                        end
                    end
                    default: key_phase_m[k] = kpd_pkg::PH_DOWN;
                endcase
            end
        end
        return res;
    endfunction

    // Called at a falling edge, returns at a falling edge with s_valid still high.
    task automatic send_sample(input logic [kpd_pkg::ROW_IN_W-1:0] row,
                               input logic [kpd_pkg::LEVEL_W-1:0]  levels,
                               input logic [kpd_pkg::TIME_W-1:0]   now);
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_row_index     <= row;
        s_column_levels <= levels;
        s_now_us        <= now;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pending_reports.push_back(debounce_row(row, levels, now));
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Writes both hold registers; block must be idle.
    task automatic set_holds(input logic [kpd_pkg::TIME_W-1:0] press_hold,
                             input logic [kpd_pkg::TIME_W-1:0] release_hold);
        cfg_valid <= 1'b1;
        cfg_index <= kpd_pkg::CFG_PRESS_HOLD;
        cfg_data  <= press_hold;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        press_hold_m = press_hold;
        @(negedge aclk);
        cfg_index <= kpd_pkg::CFG_RELEASE_HOLD;
        cfg_data  <= release_hold;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        release_hold_m = release_hold;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        hold_settings++;
    endtask

    // Keys held per row with occasional bounce; time moves forward by small steps,
    // or jumps anywhere when wild_time is set.
    task automatic scan_burst(input int count, input int max_step, input int bounce_pct,
                              input bit wild_time);
        logic [kpd_pkg::ROW_IN_W-1:0] row;
        logic [kpd_pkg::LEVEL_W-1:0]  levels;
        for (int n = 0; n < count; n++) begin
            row = kpd_pkg::ROW_IN_W'($urandom_range(0, kpd_pkg::KEY_ROWS - 1));
            if ($urandom_range(0, 99) < 8)
                held_keys[row] ^= kpd_pkg::LEVEL_W'(
                    1 << $urandom_range(0, kpd_pkg::LEVEL_W - 1));
            levels = ~held_keys[row];
            if ($urandom_range(0, 99) < bounce_pct)
                levels ^= kpd_pkg::LEVEL_W'($urandom_range(1, 15));
            if (wild_time)
                clock_us = $urandom();
            else
                clock_us += kpd_pkg::TIME_W'($urandom_range(0, max_step));
            send_sample(row, levels, clock_us);
        end
    endtask

    task automatic test_press_release();
        // default holds: 10000 press, 100000 release
        send_sample(2'd0, 4'b1110, 32'd100);
        send_sample(2'd0, 4'b1110, 32'd10099);
        send_sample(2'd0, 4'b1110, 32'd10100);
        send_sample(2'd0, 4'b1111, 32'd10200);
        send_sample(2'd0, 4'b1110, 32'd10300);   // bounce back, no report
        send_sample(2'd0, 4'b1111, 32'd10400);
        send_sample(2'd0, 4'b1111, 32'd110399);
        send_sample(2'd0, 4'b1111, 32'd110400);
        // pending press dropped by a high level
        send_sample(2'd2, 4'b1011, 32'd150000);
        send_sample(2'd2, 4'b1111, 32'd150001);
        send_sample(2'd2, 4'b1011, 32'd170000);
        wait_drained();
    endtask

    task automatic test_column_order();
        // whole row low: at most one key per sample, later columns left alone
        send_sample(2'd1, 4'b0000, 32'd200000);
        send_sample(2'd1, 4'b0000, 32'd210000);
        send_sample(2'd1, 4'b0000, 32'd220000);
        wait_drained();
    endtask

    task automatic test_time_wrap();
        send_sample(2'd3, 4'b0111, 32'hFFFF_F000);
        send_sample(2'd3, 4'b0111, 32'h0000_1710);
        wait_drained();
    endtask

    task automatic test_zero_hold();
        set_holds('0, '0);
        send_sample(2'd2, 4'b1101, 32'd500);
        send_sample(2'd2, 4'b1101, 32'd500);
        send_sample(2'd2, 4'b1111, 32'd500);
        send_sample(2'd2, 4'b1111, 32'd500);
        wait_drained();
    endtask

    task automatic test_max_hold();
        set_holds('1, '1);
        send_sample(2'd3, 4'b1110, 32'h1234_5678);
        send_sample(2'd3, 4'b1110, 32'h1234_5676);
        send_sample(2'd3, 4'b1110, 32'h1234_5677);
        send_sample(2'd3, 4'b1111, 32'h8000_0000);
        send_sample(2'd3, 4'b1111, 32'h7FFF_FFFF);
        wait_drained();
    endtask

    task automatic test_random_scan();
        clock_us = $urandom();
        set_holds(32'd20, 32'd40);
        scan_burst(250, 6, 15, 1'b0);
        wait_drained();
        set_holds('0, '0);
        scan_burst(200, 2, 10, 1'b0);
        wait_drained();
        set_holds(kpd_pkg::TIME_W'($urandom_range(1, 200)),
                  kpd_pkg::TIME_W'($urandom_range(1, 200)));
        scan_burst(200, 60, 20, 1'b0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        set_holds(32'd3, 32'd7);
        long_stall_req = 1'b1;
        scan_burst(150, 3, 10, 1'b0);
        wait_drained();
    endtask

    task automatic test_wild_time();
        set_holds(kpd_pkg::PRESS_HOLD_RST, kpd_pkg::RELEASE_HOLD_RST);
        scan_burst(150, 0, 30, 1'b1);
        wait_drained();
        set_holds($urandom(), $urandom());
        scan_burst(100, 0, 30, 1'b1);
        wait_drained();
    endtask

    task automatic test_streaming();
        idle_enable = 1'b0;
        set_holds(32'd15, 32'd30);
        scan_burst(300, 8, 10, 1'b0);
        wait_drained();
    endtask

    // result receiver: random short stalls, one long hold-off on request
    initial begin : sink
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_STALL - 1) @(negedge aclk);
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        kpd_pkg::key_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("key report with no request outstanding: valid %0d code %0d",
                       m_key_valid, m_key_code);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_key_valid !== want.key_valid) begin
                    $error("key_valid: expected %0d, got %0d", want.key_valid, m_key_valid);
                    fail_count++;
                end
                if (m_key_code !== want.key_code) begin
                    $error("key_code: expected %0d, got %0d", want.key_code, m_key_code);
                    fail_count++;
                end
                if (want.key_valid)
                    presses_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("matrix_keypad_debouncer: mismatch");
            $finish;
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_row_index     = '0;
        s_column_levels = '1;
        s_now_us        = '0;
        cfg_valid       = 1'b0;
        cfg_index       = kpd_pkg::CFG_PRESS_HOLD;
        cfg_data        = '0;
        idle_enable     = 1'b1;
        long_stall_req  = 1'b0;
        fail_count      = 0;
        samples_sent    = 0;
        presses_seen    = 0;
        hold_settings   = 0;
        quiet_cycles    = 0;
        clock_us        = '0;
        press_hold_m    = kpd_pkg::PRESS_HOLD_RST;
        release_hold_m  = kpd_pkg::RELEASE_HOLD_RST;
        for (int k = 0; k < kpd_pkg::NKEYS; k++) begin
            key_phase_m[k] = kpd_pkg::PH_IDLE;
            press_at[k]    = '0;
            release_at[k]  = '0;
        end
        for (int r = 0; r < kpd_pkg::KEY_ROWS; r++)
            held_keys[r] = '0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_press_release();
        test_column_order();
        test_time_wrap();
        test_zero_hold();
        test_max_hold();
        test_random_scan();
        test_backpressure();
        test_wild_time();
        test_streaming();

        repeat (10) @(negedge aclk);
        $display("%0d row samples checked, %0d confirmed presses, %0d hold settings",
                 samples_sent, presses_seen, hold_settings);
        $display("covered zero, maximum and random holds, time wrap and a long result stall");
        if (fail_count == 0)
            $display("matrix_keypad_debouncer: match");
        else
            $display("matrix_keypad_debouncer: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/kpd_pkg.sv
hdl/kpd_key_update.sv
hdl/kpd_row_engine.sv
hdl/matrix_keypad_debouncer.sv
tb/matrix_keypad_debouncer_tb.sv
